// ===== rtl/ased_pkg.sv =====
// Shared constants, types and helper functions of the scale and Euler angle decomposer.
package ased_pkg;

  localparam int ASED_FRAC_BITS    = 16;
  localparam int ASED_QUEUE_DEPTH  = 4;
  localparam int ASED_EL_W         = 32;
  localparam int ASED_SUM_W        = 64;
  localparam int ASED_LEN_W        = ASED_SUM_W / 2;
  localparam int ASED_SCALE_W      = 31;
  localparam int ASED_ANGLE_W      = 19;
  localparam int ASED_Q            = 30;
  localparam int ASED_CW           = 34;
  localparam int ASED_CORDIC_STEPS = 30;
  localparam int ASED_IN_W         = 10 * ASED_EL_W;
  localparam int ASED_OUT_W        = 152;

  localparam logic [ASED_SCALE_W-1:0] ASED_SCALE_MAX = '1;
  localparam logic signed [ASED_CW-1:0] ASED_PI_Q30      = 34'sd3373259426;
  localparam logic signed [ASED_CW-1:0] ASED_HALF_PI_Q30 = 34'sd1686629713;

  // One matrix after the front end: column energies plus the elements still needed.
  typedef struct packed {
    logic                        ok;
    logic [ASED_SUM_W-1:0]       sum0;
    logic [ASED_SUM_W-1:0]       sum1;
    logic [ASED_SUM_W-1:0]       sum2;
    logic signed [ASED_EL_W-1:0] e0x;
    logic signed [ASED_EL_W-1:0] e0y;
    logic signed [ASED_EL_W-1:0] e0z;
    logic signed [ASED_EL_W-1:0] e1y;
    logic signed [ASED_EL_W-1:0] e1z;
    logic signed [ASED_EL_W-1:0] e2x;
    logic signed [ASED_EL_W-1:0] e2z;
  } ased_item_t;

  function automatic logic [ASED_EL_W-1:0] ased_mag(input logic signed [ASED_EL_W-1:0] v);
    logic [ASED_EL_W-1:0] m;
    m = v[ASED_EL_W-1] ? ASED_EL_W'(-v) : ASED_EL_W'(v);
    return m;
  endfunction

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [ASED_CW-1:0] ased_atan_tab(input int i);
    logic signed [ASED_CW-1:0] t;
    case (i)
      0:       t = 34'sh03243F6A8;
      1:       t = 34'sh01DAC6705;
      2:       t = 34'sh00FADBAFC;
      3:       t = 34'sh007F56EA6;
      4:       t = 34'sh003FEAB76;
      5:       t = 34'sh001FFD55B;
      6:       t = 34'sh000FFFAAA;
      7:       t = 34'sh0007FFF55;
      8:       t = 34'sh0003FFFEA;
      9:       t = 34'sh0001FFFFD;
      default: t = (34'sd1 <<< (ASED_Q - i)) - 34'sd1;
    endcase
    return t;
  endfunction

  // pi rounded to the output format, used as the angle clamp
  function automatic logic [ASED_CW-1:0] ased_pi_lim(input int frac);
    logic [ASED_CW-1:0] p;
    int sh;
    sh = ASED_Q - frac;
    p  = ASED_PI_Q30;
    return (p + (34'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== rtl/ased_fifo.sv =====
// Short register queue between the front end and the arithmetic back end.
module ased_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue fill count lost a beat");
`endif

endmodule

// ===== rtl/ased_front.sv =====
// Front end: takes beats, flags a zero corner and forms each column's sum of squares.
module ased_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [ased_pkg::ASED_IN_W-1:0] s_tdata_i,
  output logic                        item_valid_o,
  input  logic                        item_ready_i,
  output ased_pkg::ased_item_t        item_o
);
  import ased_pkg::*;

  logic en;
  logic a_valid_q, b_valid_q;
  logic signed [ASED_EL_W-1:0] el [10];
  logic [ASED_SUM_W-1:0] sq_q [9];
  logic ok_a_q;
  logic signed [ASED_EL_W-1:0] e0x_q, e0y_q, e0z_q, e1y_q, e1z_q, e2x_q, e2z_q;
  ased_item_t item_q;

  assign en           = !b_valid_q || item_ready_i;
  assign s_tready_o   = en;
  assign item_valid_o = b_valid_q;
  assign item_o       = item_q;

  for (genvar j = 0; j < 10; j++) begin : g_el
    assign el[j] = s_tdata_i[j*ASED_EL_W +: ASED_EL_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_tvalid_i;
      b_valid_q <= a_valid_q;
    end
  end

  // stage A: squares of the magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 9; j++) begin
        sq_q[j] <= ASED_SUM_W'(ased_mag(el[j])) * ASED_SUM_W'(ased_mag(el[j]));
      end
      ok_a_q <= (el[9] != '0);
      e0x_q  <= el[0];
      e0y_q  <= el[1];
      e0z_q  <= el[2];
      e1y_q  <= el[4];
      e1z_q  <= el[5];
      e2x_q  <= el[6];
      e2z_q  <= el[8];
    end
  end

  // stage B: column sums, fits 64 bits since each square is at most 2^62
  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q.ok   <= ok_a_q;
      item_q.sum0 <= sq_q[0] + sq_q[1] + sq_q[2];
      item_q.sum1 <= sq_q[3] + sq_q[4] + sq_q[5];
      item_q.sum2 <= sq_q[6] + sq_q[7] + sq_q[8];
      item_q.e0x  <= e0x_q;
      item_q.e0y  <= e0y_q;
      item_q.e0z  <= e0z_q;
      item_q.e1y  <= e1y_q;
      item_q.e1z  <= e1z_q;
      item_q.e2x  <= e2x_q;
      item_q.e2z  <= e2z_q;
    end
  end

endmodule

// ===== rtl/ased_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side payload.
module ased_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [IN_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic [IN_W/2-1:0]    root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int STEPS = IN_W / 2;

  logic [IN_W-1:0]   v_q [STEPS-1];
  logic [IN_W-1:0]   r_q [STEPS];
  logic [SIDE_W-1:0] s_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [IN_W:0] BIT = (IN_W + 1)'(1) << (IN_W - 2 - 2 * k);
    logic [IN_W-1:0]   v_in, r_in;
    logic [SIDE_W-1:0] s_in;
    logic [IN_W:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
      assign s_in = s_q[k-1];
    end

    assign trial = {1'b0, r_in} + BIT;
    assign take  = ({1'b0, v_in} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k] <= s_in;
        r_q[k] <= take ? (r_in >> 1) + BIT[IN_W-1:0] : (r_in >> 1);
      end
    end

    if (k < STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[k] <= take ? v_in - trial[IN_W-1:0] : v_in;
        end
      end
    end
  end

  assign root_o = r_q[STEPS-1][STEPS-1:0];
  assign side_o = s_q[STEPS-1];

endmodule

// ===== rtl/ased_div.sv =====
// Pipelined restoring divider: (mag << FRAC_BITS) / den, quotient at most 2^FRAC_BITS.
module ased_div #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [ased_pkg::ASED_EL_W-1:0]  mag_i,
  input  logic [ased_pkg::ASED_LEN_W-1:0] den_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic [FRAC_BITS:0]              quo_o,
  output logic [SIDE_W-1:0]               side_o
);
  import ased_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int NUM_W = ASED_EL_W + FRAC_BITS;

  logic [NUM_W-1:0]      r_q [QW-1];
  logic [ASED_LEN_W-1:0] d_q [QW-1];
  logic [QW-1:0]         q_q [QW];
  logic [SIDE_W-1:0]     s_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH = QW - 1 - k;
    logic [NUM_W-1:0]      r_in, dk;
    logic [ASED_LEN_W-1:0] d_in;
    logic [QW-1:0]         q_in;
    logic [SIDE_W-1:0]     s_in;
    logic                  take;

    if (k == 0) begin : g_first
      assign r_in = {mag_i, {FRAC_BITS{1'b0}}};
      assign d_in = den_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign q_in = q_q[k-1];
      assign s_in = s_q[k-1];
    end

    // a zero length goes with an all-zero column, so the quotient stays zero
    assign dk   = NUM_W'(d_in) << SH;
    assign take = (d_in != '0) && (r_in >= dk);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k] <= {q_in[QW-2:0], take};
        s_q[k] <= s_in;
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= take ? r_in - dk : r_in;
          d_q[k] <= d_in;
        end
      end
    end
  end

  assign quo_o  = q_q[QW-1];
  assign side_o = s_q[QW-1];

endmodule

// ===== rtl/ased_cordic.sv =====
// Pipelined CORDIC atan2 in Q30 with quadrant pre-turn, rounding and clamp to pi.
module ased_cordic #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [FRAC_BITS+1:0]       y_i,
  input  logic signed [FRAC_BITS+1:0]       x_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic [ased_pkg::ASED_ANGLE_W-1:0] angle_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import ased_pkg::*;

  localparam int N  = ASED_CORDIC_STEPS;
  localparam int SH = ASED_Q - FRAC_BITS;
  localparam logic [ASED_CW-1:0] LIM = ased_pi_lim(FRAC_BITS);

  logic signed [ASED_CW-1:0] x_q [N];
  logic signed [ASED_CW-1:0] y_q [N];
  logic signed [ASED_CW-1:0] z_q [N+1];
  logic                      zf_q [N+1];
  logic [SIDE_W-1:0]         s_q [N+1];

  logic signed [ASED_CW-1:0] xs, ys;
  logic [ASED_ANGLE_W-1:0]   angle_q;
  logic [SIDE_W-1:0]         side_q;

  assign xs = ASED_CW'(x_i) <<< SH;
  assign ys = ASED_CW'(y_i) <<< SH;

  // pre-turn by +-pi/2 so the vector starts in the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zf_q[0] <= (x_i == '0) && (y_i == '0);
      s_q[0]  <= side_i;
      if (xs < 0) begin
        if (ys >= 0) begin
          x_q[0] <= ys;
          y_q[0] <= -xs;
          z_q[0] <= ASED_HALF_PI_Q30;
        end else begin
          x_q[0] <= -ys;
          y_q[0] <= xs;
          z_q[0] <= -ASED_HALF_PI_Q30;
        end
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ASED_CW-1:0] TAB = ased_atan_tab(i);
    logic signed [ASED_CW-1:0] dx, dy;
    logic                      up;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign up = (y_q[i] > 0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]  <= up ? z_q[i] + TAB : z_q[i] - TAB;
        zf_q[i+1] <= zf_q[i];
        s_q[i+1]  <= s_q[i];
      end
    end

    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[i+1] <= up ? x_q[i] + dx : x_q[i] - dx;
          y_q[i+1] <= up ? y_q[i] - dy : y_q[i] + dy;
        end
      end
    end
  end

  // round half away from zero, clamp to +-pi
  logic                    neg;
  logic [ASED_CW-1:0]      mag, rnd, clm, res;
  assign neg = z_q[N][ASED_CW-1];
  assign mag = neg ? ASED_CW'(-z_q[N]) : ASED_CW'(z_q[N]);
  assign rnd = (mag + (ASED_CW'(1) << (SH - 1))) >> SH;
  assign clm = (rnd > LIM) ? LIM : rnd;
  assign res = neg ? -clm : clm;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zf_q[N] ? '0 : res[ASED_ANGLE_W-1:0];
      side_q  <= s_q[N];
    end
  end

  assign angle_o = angle_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/ased_back.sv =====
// Back end: lengths, normalisation, asin cosine, 3 atan2s; one beat a cycle unless stalled.
module ased_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  ased_pkg::ased_item_t            item_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [ased_pkg::ASED_OUT_W-1:0] m_tdata_o,
  output logic                            m_tuser_o
);
  import ased_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 2;
  localparam int SW  = ASED_SCALE_W;
  localparam int EW  = ASED_EL_W;
  localparam int AW  = ASED_ANGLE_W;
  localparam int CQ_W = 2 * FRAC_BITS + 2;
  localparam int CS_W = 1 + 3 * SW + 7 * NW;
  localparam int LAT = ASED_LEN_W + QW + 1 + QW + ASED_CORDIC_STEPS + 2;

  logic en;
  logic [LAT-1:0] valid_q;

  assign en           = !valid_q[LAT-1] || m_tready_i;
  assign item_ready_o = en;
  assign m_tvalid_o   = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], item_valid_i};
    end
  end

  // column lengths
  logic [ASED_LEN_W-1:0] l0, l1, l2;
  logic                  ok_l;
  logic signed [EW-1:0]  e0x, e0y, e0z, e1y, e1z, e2x, e2z;

  ased_isqrt #(.IN_W(ASED_SUM_W), .SIDE_W(1 + 3 * EW)) u_len0 (
    .clk_i, .en_i(en), .rad_i(item_i.sum0),
    .side_i({item_i.ok, item_i.e0x, item_i.e0y, item_i.e0z}),
    .root_o(l0), .side_o({ok_l, e0x, e0y, e0z})
  );
  ased_isqrt #(.IN_W(ASED_SUM_W), .SIDE_W(2 * EW)) u_len1 (
    .clk_i, .en_i(en), .rad_i(item_i.sum1), .side_i({item_i.e1y, item_i.e1z}),
    .root_o(l1), .side_o({e1y, e1z})
  );
  ased_isqrt #(.IN_W(ASED_SUM_W), .SIDE_W(2 * EW)) u_len2 (
    .clk_i, .en_i(en), .rad_i(item_i.sum2), .side_i({item_i.e2x, item_i.e2z}),
    .root_o(l2), .side_o({e2x, e2z})
  );

  logic [SW-1:0] sx_l, sy_l, sz_l;
  assign sx_l = l0[ASED_LEN_W-1] ? ASED_SCALE_MAX : l0[SW-1:0];
  assign sy_l = l1[ASED_LEN_W-1] ? ASED_SCALE_MAX : l1[SW-1:0];
  assign sz_l = l2[ASED_LEN_W-1] ? ASED_SCALE_MAX : l2[SW-1:0];

  // normalisation, magnitudes only; signs ride alongside
  logic [QW-1:0] q0x, q0y, q0z, q1y, q1z, q2x, q2z;
  logic          g0x, g0y, g0z, g1y, g1z, g2x, g2z, ok_d;
  logic [SW-1:0] sx_d, sy_d, sz_d;

  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(2 + SW)) u_div0x (
    .clk_i, .en_i(en), .mag_i(ased_mag(e0x)), .den_i(l0),
    .side_i({ok_l, e0x[EW-1], sx_l}), .quo_o(q0x), .side_o({ok_d, g0x, sx_d})
  );
  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div0y (
    .clk_i, .en_i(en), .mag_i(ased_mag(e0y)), .den_i(l0),
    .side_i(e0y[EW-1]), .quo_o(q0y), .side_o(g0y)
  );
  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div0z (
    .clk_i, .en_i(en), .mag_i(ased_mag(e0z)), .den_i(l0),
    .side_i(e0z[EW-1]), .quo_o(q0z), .side_o(g0z)
  );
  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1 + SW)) u_div1y (
    .clk_i, .en_i(en), .mag_i(ased_mag(e1y)), .den_i(l1),
    .side_i({e1y[EW-1], sy_l}), .quo_o(q1y), .side_o({g1y, sy_d})
  );
  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div1z (
    .clk_i, .en_i(en), .mag_i(ased_mag(e1z)), .den_i(l1),
    .side_i(e1z[EW-1]), .quo_o(q1z), .side_o(g1z)
  );
  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1 + SW)) u_div2x (
    .clk_i, .en_i(en), .mag_i(ased_mag(e2x)), .den_i(l2),
    .side_i({e2x[EW-1], sz_l}), .quo_o(q2x), .side_o({g2x, sz_d})
  );
  ased_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div2z (
    .clk_i, .en_i(en), .mag_i(ased_mag(e2z)), .den_i(l2),
    .side_i(e2z[EW-1]), .quo_o(q2z), .side_o(g2z)
  );

  // signed unit vector elements; s = -n0z, and s squared for the cosine
  logic signed [NW-1:0] n0x_q, n0y_q, s_q, n1y_q, n1z_q, n2x_q, n2z_q;
  logic [2*QW-1:0]      s2_q;
  logic                 ok_q;
  logic [SW-1:0]        sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n0x_q <= g0x ? -$signed({1'b0, q0x}) : $signed({1'b0, q0x});
      n0y_q <= g0y ? -$signed({1'b0, q0y}) : $signed({1'b0, q0y});
      s_q   <= g0z ? $signed({1'b0, q0z}) : -$signed({1'b0, q0z});
      n1y_q <= g1y ? -$signed({1'b0, q1y}) : $signed({1'b0, q1y});
      n1z_q <= g1z ? -$signed({1'b0, q1z}) : $signed({1'b0, q1z});
      n2x_q <= g2x ? -$signed({1'b0, q2x}) : $signed({1'b0, q2x});
      n2z_q <= g2z ? -$signed({1'b0, q2z}) : $signed({1'b0, q2z});
      s2_q  <= (2 * QW)'(q0z) * (2 * QW)'(q0z);
      ok_q  <= ok_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sz_q  <= sz_d;
    end
  end

  // cosine of y: sqrt(1 - s^2), never negative since |s| <= 1
  logic [CQ_W-1:0]      rad_c;
  logic [QW-1:0]        c_r;
  logic                 ok_c;
  logic [SW-1:0]        sx_c, sy_c, sz_c;
  logic signed [NW-1:0] n0x_c, n0y_c, s_c, n1y_c, n1z_c, n2x_c, n2z_c;

  assign rad_c = (CQ_W'(1) << (2 * FRAC_BITS)) - CQ_W'(s2_q);

  ased_isqrt #(.IN_W(CQ_W), .SIDE_W(CS_W)) u_cos (
    .clk_i, .en_i(en), .rad_i(rad_c),
    .side_i({ok_q, sx_q, sy_q, sz_q, s_q, n0x_q, n0y_q, n1y_q, n1z_q, n2x_q, n2z_q}),
    .root_o(c_r),
    .side_o({ok_c, sx_c, sy_c, sz_c, s_c, n0x_c, n0y_c, n1y_c, n1z_c, n2x_c, n2z_c})
  );

  // gimbal lock: x from the other pair, z forced to zero via a null vector
  logic                 gimbal;
  logic signed [NW-1:0] ax_y, ax_x, az_y, az_x, ay_x;

  assign gimbal = (c_r == '0);
  assign ay_x   = $signed({1'b0, c_r});
  assign ax_y   = gimbal ? -n2x_c : n1z_c;
  assign ax_x   = gimbal ? n1y_c : n2z_c;
  assign az_y   = gimbal ? '0 : n0y_c;
  assign az_x   = gimbal ? '0 : n0x_c;

  logic [AW-1:0] ang_x, ang_y, ang_z;
  logic          ok_o;
  logic [SW-1:0] sx_o, sy_o, sz_o;

  ased_cordic #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1 + SW)) u_atan_x (
    .clk_i, .en_i(en), .y_i(ax_y), .x_i(ax_x), .side_i({ok_c, sx_c}),
    .angle_o(ang_x), .side_o({ok_o, sx_o})
  );
  ased_cordic #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_atan_y (
    .clk_i, .en_i(en), .y_i(s_c), .x_i(ay_x), .side_i(sy_c),
    .angle_o(ang_y), .side_o(sy_o)
  );
  ased_cordic #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_atan_z (
    .clk_i, .en_i(en), .y_i(az_y), .x_i(az_x), .side_i(sz_c),
    .angle_o(ang_z), .side_o(sz_o)
  );

  assign m_tuser_o = ok_o;
  assign m_tdata_o = ok_o ? {(ASED_OUT_W - 3 * AW - 3 * SW)'(0), sz_o, sy_o, sx_o,
                             ang_z, ang_y, ang_x}
                          : '0;

endmodule

// ===== rtl/affine_scale_euler_decompose.sv =====
// Top level of the transform decomposer: per-column scale and XYZ Euler angles.
//
// Takes the upper 3x3 of a column-major transform plus its bottom-right
// element (all signed Q16.16) and returns the three column lengths as
// saturating scales and the X, Y, Z Euler angles in radians. A zero corner
// element gives ok = 0 with all other fields zero; a zero-length column
// normalises to zero; in gimbal lock (cos y exactly zero) angle_z is zero.
// Throughput is one beat per clock while results are taken: every unit is
// fully pipelined. Each beat passes the front end stages A (squares) and B
// (column sums), then the queue, then the back end, whose depth is set by
// the 32-stage length square root, the FRAC_BITS+1 stage dividers and cosine
// root, one normalisation register, and the 32-stage CORDIC atan2 units. The
// back end stalls as a whole when the result is not taken; the front end
// keeps accepting until its 4-deep queue fills.
// No state survives an item; there is no clearing pass after reset.
module affine_scale_euler_decompose #(
  parameter int FRAC_BITS = ased_pkg::ASED_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z, w_corner
  input  logic [ased_pkg::ASED_IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, 2 zero pad bits
  output logic [ased_pkg::ASED_OUT_W-1:0]  m_axis_tdata,
  // ok
  output logic                             m_axis_tuser
);
  import ased_pkg::*;

  ased_item_t front_item, queue_item;
  logic       front_valid, queue_full, queue_empty, back_ready;

  // front end: corner check and column energies
  ased_front u_front (
    .clk_i,
    .rst_ni,
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .item_valid_o (front_valid),
    .item_ready_i (!queue_full),
    .item_o       (front_item)
  );

  // decoupling queue so either side can stall alone
  ased_fifo #(.W($bits(ased_item_t)), .DEPTH(ASED_QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (front_valid && !queue_full),
    .data_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (back_ready && !queue_empty),
    .data_o  (queue_item),
    .empty_o (queue_empty)
  );

  // back end: roots, divides and CORDIC, last stage doubles as output register
  ased_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (!queue_empty),
    .item_ready_o (back_ready),
    .item_i       (queue_item),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule
